// ===== hw/rtl/tcc_pkg.sv =====
// Shared types, codes and constants for the text console with cursor and scroll.
// Used by tcc_front, tcc_queue, tcc_back and text_console_cursor_scroll.
`default_nettype none

package tcc_pkg;

  // default screen geometry
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // widths that hold the largest supported geometry
  localparam int COL_MAX_W = 7;
  localparam int ROW_MAX_W = 6;
  localparam int COL_SUM_W = 8;

  // cell contents
  localparam logic [15:0] BLANK_CELL = 16'h0020;

  // character codes
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_RETURN    = 8'h0D;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  // request modes
  localparam logic [1:0] MODE_PUT   = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;
  localparam logic [1:0] MODE_CLEAR = 2'd3;

  // back-end operations
  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAB  = 1'b1;

  // configuration reset values
  localparam logic [7:0] ATTR_RESET = 8'd7;
  localparam logic [6:0] TAB_RESET  = 7'd8;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] char_code;
    logic [6:0] col;
    logic [4:0] row;
  } in_t;

  typedef struct packed {
    logic [15:0] cell_value;
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic        scrolled;
  } out_t;

  // one classified request handed from front to back
  typedef struct packed {
    logic [1:0]           op;
    logic                 scroll;
    logic                 read_ok;
    logic [COL_MAX_W-1:0] col;
    logic [ROW_MAX_W-1:0] row;
    logic [15:0]          data;
    out_t                 res;
  } entry_t;

  // back-end status seen by the top level
  typedef struct packed {
    logic init;
    logic sweeping;
  } bk_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/text_console_cursor_scroll.sv =====
// Top level of the text console: configuration registers, front end, request
// queue and back end. Depends on tcc_pkg, tcc_front, tcc_queue and tcc_back.
//
//   channel   ports                          handshake
//   request   start, busy, cmd               taken when start && !busy
//   result    done, result                   one-cycle strobe, no stall
//   config    cfg_we, cfg_index, cfg_data    written when cfg_we
//
// The front takes one request a cycle while the queue has room and no power-up
// blanking runs. In the back a write, a put or an out-of-range read finishes in
// ST_RUN, an in-range read also passes ST_READ (registered memory port). A
// scroll adds a sweep that blanks one row and a clear one that blanks all
// ROWS*COLUMNS cells; both use the single memory write port. After reset the
// memory is blanked with busy held high, and results are registered in the back.
`default_nettype none

module text_console_cursor_scroll #(
  parameter int COLUMNS     = tcc_pkg::COLUMNS_DEF,
  parameter int ROWS        = tcc_pkg::ROWS_DEF,
  parameter int QUEUE_DEPTH = tcc_pkg::QUEUE_DEPTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire tcc_pkg::in_t                    cmd,
  output logic                                 done,
  output tcc_pkg::out_t                        result,
  input  wire logic                            cfg_we,
  input  wire logic [tcc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [7:0]                      cfg_data
);
  import tcc_pkg::*;

  logic [7:0]  text_attribute;
  logic [6:0]  tab_advance;
  logic        accept;
  entry_t      front_entry;
  entry_t      q_head;
  logic        q_pop, q_full, q_empty;
  bk_status_t  bk_status;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      text_attribute <= ATTR_RESET;
      tab_advance    <= TAB_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ATTR: text_attribute <= cfg_data;
        CFG_TAB:  tab_advance    <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // request handshake
  assign busy   = q_full || bk_status.init;
  assign accept = start && !busy;

  tcc_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .cmd            (cmd),
    .text_attribute (text_attribute),
    .tab_advance    (tab_advance),
    .entry          (front_entry)
  );

  tcc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_entry (front_entry),
    .pop        (q_pop),
    .head       (q_head),
    .full       (q_full),
    .empty      (q_empty)
  );

  tcc_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .done    (done),
    .result  (result),
    .status  (bk_status)
  );

`ifndef SYNTHESIS
  // no result leaves while the power-up blanking runs
  a_no_done_in_init: assert property (@(posedge clk) disable iff (rst)
    bk_status.init |-> !done)
    else $error("result strobe during initial blanking");

  // an accepted request is queued on the next cycle
  a_accept_queued: assert property (@(posedge clk) disable iff (rst)
    accept |=> !q_empty)
    else $error("accepted request missing from queue");

  // the back end takes no request while it blanks memory
  a_no_pop_in_sweep: assert property (@(posedge clk) disable iff (rst)
    bk_status.sweeping |-> !q_pop)
    else $error("queue popped during blanking sweep");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/tcc_front.sv =====
// Front end: owns the cursor, decodes each request and classifies it into a
// back-end operation. Depends on tcc_pkg.
`default_nettype none

module tcc_front #(
  parameter int COLUMNS = tcc_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcc_pkg::ROWS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          accept,
  input  wire tcc_pkg::in_t  cmd,
  input  wire logic [7:0]    text_attribute,
  input  wire logic [6:0]    tab_advance,
  output tcc_pkg::entry_t    entry
);
  import tcc_pkg::*;

  localparam int CW = $clog2(COLUMNS);
  localparam int RW = $clog2(ROWS);

  logic [CW-1:0] cur_col, cur_col_next;
  logic [RW-1:0] cur_row, cur_row_next;

  logic [COL_SUM_W-1:0] col_n;
  logic [RW:0]          row_n;
  logic                 scroll;
  logic                 in_range;

  // cursor update and classification
  always_comb begin
    col_n        = COL_SUM_W'(cur_col);
    row_n        = (RW+1)'(cur_row);
    scroll       = 1'b0;
    in_range     = (cmd.col < COLUMNS) && (cmd.row < ROWS);
    entry        = '0;
    entry.op     = OP_NONE;
    entry.col    = COL_MAX_W'(cur_col);
    entry.row    = ROW_MAX_W'(cur_row);
    entry.data   = {text_attribute, cmd.char_code};
    cur_col_next = cur_col;
    cur_row_next = cur_row;

    case (cmd.mode)
      MODE_PUT: begin
        if (cmd.char_code == CH_BACKSPACE) begin
          if (cur_col != '0) begin
            col_n      = COL_SUM_W'(cur_col) - 1'b1;
            entry.op   = OP_WRITE;
            entry.col  = COL_MAX_W'(cur_col - 1'b1);
            entry.data = {text_attribute, CH_SPACE};
          end
        end else if (cmd.char_code == CH_RETURN) begin
          col_n = '0;
        end else if (cmd.char_code == CH_NEWLINE) begin
          col_n = '0;
          row_n = row_n + 1'b1;
        end else if (cmd.char_code == CH_TAB) begin
          col_n = col_n + COL_SUM_W'(tab_advance);
        end else if (cmd.char_code >= CH_SPACE) begin
          entry.op = OP_WRITE;
          col_n    = col_n + 1'b1;
        end
        // wrap past the last column
        if (col_n >= COL_SUM_W'(COLUMNS)) begin
          col_n = '0;
          row_n = row_n + 1'b1;
        end
        // scroll past the last row
        if (row_n >= (RW+1)'(ROWS)) begin
          scroll = 1'b1;
          row_n  = (RW+1)'(ROWS - 1);
        end
        cur_col_next = CW'(col_n);
        cur_row_next = RW'(row_n);
      end
      MODE_WRITE: begin
        if (in_range) begin
          entry.op = OP_WRITE;
        end
        entry.col = COL_MAX_W'(cmd.col);
        entry.row = ROW_MAX_W'(cmd.row);
      end
      MODE_READ: begin
        entry.op      = OP_READ;
        entry.read_ok = in_range;
        entry.col     = COL_MAX_W'(cmd.col);
        entry.row     = ROW_MAX_W'(cmd.row);
      end
      default: begin
        entry.op     = OP_CLEAR;
        cur_col_next = '0;
        cur_row_next = '0;
      end
    endcase

    entry.scroll         = scroll;
    entry.res.cell_value = '0;
    entry.res.cursor_col = 7'(cur_col_next);
    entry.res.cursor_row = 5'(cur_row_next);
    entry.res.scrolled   = scroll;
  end

  // cursor registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col <= '0;
      cur_row <= '0;
    end else if (accept) begin
      cur_col <= cur_col_next;
      cur_row <= cur_row_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tcc_queue.sv =====
// Small register queue of classified requests between front and back.
// Depends on tcc_pkg for the entry type.
`default_nettype none

module tcc_queue #(
  parameter int DEPTH = tcc_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire tcc_pkg::entry_t  push_entry,
  input  wire logic             pop,
  output tcc_pkg::entry_t       head,
  output logic                  full,
  output logic                  empty
);
  import tcc_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  entry_t        slots [DEPTH];
  logic [PW-1:0] rd_ptr, wr_ptr;
  logic [NW-1:0] count;

  assign head  = slots[rd_ptr];
  assign full  = (count == NW'(DEPTH));
  assign empty = (count == '0);

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tcc_back.sv =====
// Back end: screen memory with a rotating row offset for scrolling, a blanking
// sweep for scroll and clear, and the result register. Depends on tcc_pkg.
`default_nettype none

module tcc_back #(
  parameter int COLUMNS = tcc_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcc_pkg::ROWS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_empty,
  input  wire tcc_pkg::entry_t  q_head,
  output logic                  q_pop,
  output logic                  done,
  output tcc_pkg::out_t         result,
  output tcc_pkg::bk_status_t   status
);
  import tcc_pkg::*;

  localparam int CW     = $clog2(COLUMNS);
  localparam int RW     = $clog2(ROWS);
  localparam int CELLS  = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);

  localparam logic [1:0] ST_RUN   = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_SWEEP = 2'd2;

  logic [15:0]       mem [CELLS];
  logic [15:0]       mem_q;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, cell_addr;
  logic [15:0]       mem_wdata;

  logic [1:0]        state, state_next;
  logic [RW-1:0]     offset, offset_next;
  logic [ADDR_W-1:0] sweep_addr, sweep_addr_next;
  logic [ADDR_W-1:0] sweep_last, sweep_last_next;
  logic              init, init_next;
  logic              done_next;
  out_t              result_next;
  out_t              pend, pend_next;

  logic [RW:0]       row_sum;
  logic [RW-1:0]     phys_row;
  logic [ADDR_W-1:0] top_base;

  // logical row to physical row, then cell address
  always_comb begin
    row_sum   = (RW+1)'(RW'(q_head.row)) + (RW+1)'(offset);
    phys_row  = (row_sum >= (RW+1)'(ROWS)) ? RW'(row_sum - (RW+1)'(ROWS)) : RW'(row_sum);
    cell_addr = ADDR_W'(phys_row) * ADDR_W'(COLUMNS) + ADDR_W'(CW'(q_head.col));
    top_base  = ADDR_W'(offset) * ADDR_W'(COLUMNS);
  end

  // sequencing
  always_comb begin
    state_next      = state;
    offset_next     = offset;
    sweep_addr_next = sweep_addr;
    sweep_last_next = sweep_last;
    init_next       = init;
    done_next       = 1'b0;
    result_next     = result;
    pend_next       = pend;
    q_pop           = 1'b0;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    mem_waddr       = cell_addr;
    mem_wdata       = q_head.data;

    case (state)
      ST_RUN: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          case (q_head.op)
            OP_READ: begin
              if (q_head.read_ok) begin
                mem_re     = 1'b1;
                pend_next  = q_head.res;
                state_next = ST_READ;
              end else begin
                done_next   = 1'b1;
                result_next = q_head.res;
              end
            end
            OP_WRITE: begin
              mem_we      = 1'b1;
              done_next   = 1'b1;
              result_next = q_head.res;
            end
            OP_CLEAR: begin
              offset_next     = '0;
              sweep_addr_next = '0;
              sweep_last_next = ADDR_W'(CELLS - 1);
              state_next      = ST_SWEEP;
              done_next       = 1'b1;
              result_next     = q_head.res;
            end
            default: begin
              done_next   = 1'b1;
              result_next = q_head.res;
            end
          endcase
          // old top row becomes the new bottom row and is blanked
          if (q_head.scroll) begin
            sweep_addr_next = top_base;
            sweep_last_next = top_base + ADDR_W'(COLUMNS - 1);
            offset_next     = (offset == RW'(ROWS - 1)) ? '0 : offset + 1'b1;
            state_next      = ST_SWEEP;
          end
        end
      end
      ST_READ: begin
        done_next              = 1'b1;
        result_next            = pend;
        result_next.cell_value = mem_q;
        state_next             = ST_RUN;
      end
      ST_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_addr;
        mem_wdata = BLANK_CELL;
        if (sweep_addr == sweep_last) begin
          state_next = ST_RUN;
          init_next  = 1'b0;
        end else begin
          sweep_addr_next = sweep_addr + 1'b1;
        end
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

  // screen memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q <= mem[cell_addr];
    end
  end

  // control registers, reset starts the blanking sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_SWEEP;
      offset     <= '0;
      sweep_addr <= '0;
      sweep_last <= ADDR_W'(CELLS - 1);
      init       <= 1'b1;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      offset     <= offset_next;
      sweep_addr <= sweep_addr_next;
      sweep_last <= sweep_last_next;
      init       <= init_next;
      done       <= done_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    result <= result_next;
    pend   <= pend_next;
  end

  assign status.init     = init;
  assign status.sweeping = (state == ST_SWEEP);

endmodule

`default_nettype wire

// ===== dv/tb_text_console_cursor_scroll.sv =====
// Self-checking testbench for text_console_cursor_scroll: directed table, then random phases.
// Uses tcc_pkg for request/result types, mode codes, character codes and register indexes.
// Builds with tcc_pkg and the text_console_cursor_scroll RTL.
`default_nettype none

module tb_text_console_cursor_scroll;
  import tcc_pkg::*;

  localparam int CYCLE_LIMIT     = 600000;
  localparam int ITEMS_PER_PHASE = 205;
  localparam int RANDOM_PHASES   = 6;

  // one row of the directed table: request, whether the result is typed in, and that result
  typedef struct packed {
    in_t  req;
    logic known;
    out_t want;
  } dir_row_t;

  localparam int NUM_DIRECTED = 24;
  localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
    '{'{MODE_READ,  8'h00,        7'd0,   5'd0},  1'b1, '{16'h0020, 7'd0, 5'd0, 1'b0}},
    '{'{MODE_PUT,   8'h41,        7'd0,   5'd0},  1'b1, '{16'h0000, 7'd1, 5'd0, 1'b0}},
    '{'{MODE_READ,  8'h00,        7'd0,   5'd0},  1'b1, '{16'h0741, 7'd1, 5'd0, 1'b0}},
    '{'{MODE_PUT,   CH_BACKSPACE, 7'd0,   5'd0},  1'b1, '{16'h0000, 7'd0, 5'd0, 1'b0}},
    '{'{MODE_PUT,   CH_BACKSPACE, 7'd0,   5'd0},  1'b1, '{16'h0000, 7'd0, 5'd0, 1'b0}},
    '{'{MODE_PUT,   CH_TAB,       7'd0,   5'd0},  1'b1, '{16'h0000, 7'd8, 5'd0, 1'b0}},
    '{'{MODE_PUT,   CH_RETURN,    7'd0,   5'd0},  1'b1, '{16'h0000, 7'd0, 5'd0, 1'b0}},
    '{'{MODE_PUT,   8'h1F,        7'd127, 5'd31}, 1'b0, '0},
    '{'{MODE_PUT,   8'hFF,        7'd0,   5'd0},  1'b0, '0},
    '{'{MODE_PUT,   CH_NEWLINE,   7'd0,   5'd0},  1'b0, '0},
    '{'{MODE_WRITE, 8'h00,        7'd79,  5'd24}, 1'b1, '{16'h0000, 7'd0, 5'd1, 1'b0}},
    '{'{MODE_READ,  8'h00,        7'd79,  5'd24}, 1'b1, '{16'h0700, 7'd0, 5'd1, 1'b0}},
    '{'{MODE_WRITE, 8'hAA,        7'd127, 5'd31}, 1'b1, '{16'h0000, 7'd0, 5'd1, 1'b0}},
    '{'{MODE_READ,  8'h00,        7'd127, 5'd31}, 1'b1, '{16'h0000, 7'd0, 5'd1, 1'b0}},
    '{'{MODE_READ,  8'h00,        7'd80,  5'd0},  1'b1, '{16'h0000, 7'd0, 5'd1, 1'b0}},
    '{'{MODE_READ,  8'h00,        7'd0,   5'd25}, 1'b1, '{16'h0000, 7'd0, 5'd1, 1'b0}},
    '{'{MODE_WRITE, 8'h55,        7'd0,   5'd25}, 1'b0, '0},
    '{'{MODE_READ,  8'h00,        7'd0,   5'd0},  1'b0, '0},
    '{'{MODE_CLEAR, 8'h00,        7'd0,   5'd0},  1'b1, '{16'h0000, 7'd0, 5'd0, 1'b0}},
    '{'{MODE_READ,  8'h00,        7'd79,  5'd24}, 1'b1, '{16'h0020, 7'd0, 5'd0, 1'b0}},
    '{'{MODE_PUT,   CH_SPACE,     7'd0,   5'd0},  1'b1, '{16'h0000, 7'd1, 5'd0, 1'b0}},
    '{'{MODE_READ,  8'h00,        7'd0,   5'd0},  1'b1, '{16'h0720, 7'd1, 5'd0, 1'b0}},
    '{'{MODE_PUT,   8'h7E,        7'd0,   5'd0},  1'b0, '0},
    '{'{MODE_PUT,   CH_BACKSPACE, 7'd0,   5'd0},  1'b0, '0}
  };

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  in_t                  cmd = '0;
  logic                 done;
  out_t                 result;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_ATTR;
  logic [7:0]           cfg_data = '0;

  // console shadow: screen, cursor and registers
  logic [15:0] screen_mem [ROWS_DEF][COLUMNS_DEF];
  logic [6:0]  cur_col;
  logic [4:0]  cur_row;
  logic [7:0]  attr_byte;
  logic [6:0]  tab_step;

  out_t pending_results [$];
  int   mismatches = 0;
  int   cycles = 0;

  text_console_cursor_scroll i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // blank the whole screen and home the cursor
  function automatic void blank_screen();
    for (int r = 0; r < ROWS_DEF; r++)
      for (int c = 0; c < COLUMNS_DEF; c++)
        screen_mem[r][c] = BLANK_CELL;
    cur_col = '0;
    cur_row = '0;
  endfunction

  // apply one request to the shadow console and return the result it gives
  function automatic out_t console_step(in_t req);
    out_t res;
    int   c;
    int   r;
    res = '0;
    c = int'(cur_col);
    r = int'(cur_row);
    case (req.mode)
      MODE_PUT: begin
        if (req.char_code == CH_BACKSPACE) begin
          if (c != 0) begin
            c--;
            screen_mem[r][c] = {attr_byte, CH_SPACE};
          end
        end else if (req.char_code == CH_RETURN) begin
          c = 0;
        end else if (req.char_code == CH_NEWLINE) begin
          c = 0;
          r++;
        end else if (req.char_code == CH_TAB) begin
          c += int'(tab_step);
        end else if (req.char_code >= CH_SPACE) begin
          screen_mem[r][c] = {attr_byte, req.char_code};
          c++;
        end
        // wrap past the last column
        if (c >= COLUMNS_DEF) begin
          c = 0;
          r++;
        end
        // scroll up one row past the last row
        if (r >= ROWS_DEF) begin
          for (int y = 0; y < ROWS_DEF - 1; y++)
            for (int x = 0; x < COLUMNS_DEF; x++)
              screen_mem[y][x] = screen_mem[y+1][x];
          for (int x = 0; x < COLUMNS_DEF; x++)
            screen_mem[ROWS_DEF-1][x] = BLANK_CELL;
          r = ROWS_DEF - 1;
          res.scrolled = 1'b1;
        end
        cur_col = c[6:0];
        cur_row = r[4:0];
      end
      MODE_WRITE: begin
        if (req.col < COLUMNS_DEF && req.row < ROWS_DEF)
          screen_mem[req.row][req.col] = {attr_byte, req.char_code};
      end
      MODE_READ: begin
        if (req.col < COLUMNS_DEF && req.row < ROWS_DEF)
          res.cell_value = screen_mem[req.row][req.col];
      end
      default: begin
        blank_screen();
      end
    endcase
    res.cursor_col = cur_col;
    res.cursor_row = cur_row;
    return res;
  endfunction

  // random request, mostly printable text and newlines so the screen wraps and scrolls
  function automatic in_t random_request();
    in_t req;
    int  pick;
    int  kind;
    req.char_code = 8'($urandom_range(255));
    req.col       = 7'($urandom_range(127));
    req.row       = 5'($urandom_range(31));
    pick = $urandom_range(999);
    if (pick < 3) begin
      req.mode = MODE_CLEAR;
    end else if (pick < 280) begin
      req.mode = (pick < 130) ? MODE_WRITE : MODE_READ;
      // mostly in-range addresses, the rest anywhere in the field
      if ($urandom_range(99) < 85) begin
        req.col = 7'($urandom_range(COLUMNS_DEF - 1));
        req.row = 5'($urandom_range(ROWS_DEF - 1));
      end
    end else begin
      req.mode = MODE_PUT;
      kind = $urandom_range(99);
      if (kind < 18)      req.char_code = CH_NEWLINE;
      else if (kind < 23) req.char_code = CH_TAB;
      else if (kind < 27) req.char_code = CH_RETURN;
      else if (kind < 32) req.char_code = CH_BACKSPACE;
      else if (kind < 35) req.char_code = 8'($urandom_range(31));
      else                req.char_code = 8'($urandom_range(255, 32));
    end
    return req;
  endfunction

  // field-by-field compare
  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
    end
  endtask

  // result monitor: each strobe pops the oldest expected result
  always @(posedge clk) begin
    out_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result %0h with none pending", $time, result);
      end else begin
        want = pending_results.pop_front();
        check_field("cell_value", want.cell_value, result.cell_value);
        check_field("cursor_col", 16'(want.cursor_col), 16'(result.cursor_col));
        check_field("cursor_row", 16'(want.cursor_row), 16'(result.cursor_row));
        check_field("scrolled", 16'(want.scrolled), 16'(result.scrolled));
      end
    end
  end

  // hold start high until the request is taken, then predict it
  task automatic issue(in_t req, logic known, out_t want);
    out_t predicted;
    start <= 1'b1;
    cmd   <= req;
    do @(posedge clk); while (busy);
    predicted = console_step(req);
    pending_results.push_back(known ? want : predicted);
  endtask

  // random gaps between requests
  task automatic sender_gap(int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // stop sending and wait for every pending result and a free front end
  task automatic drain();
    if (pending_results.size() != 0 || busy) begin
      start <= 1'b0;
      while (pending_results.size() != 0 || busy) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    if (idx == CFG_ATTR) attr_byte = value;
    else                 tab_step  = value[6:0];
  endtask

  // stimulus
  initial begin
    int idle_pct;
    blank_screen();
    attr_byte = ATTR_RESET;
    tab_step  = TAB_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed table with register reset values
    foreach (DIRECTED[i]) begin
      sender_gap(7);
      issue(DIRECTED[i].req, DIRECTED[i].known, DIRECTED[i].want);
    end

    // random phases, registers changed only while idle
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain();
      case (phase)
        0: begin
          write_reg(CFG_ATTR, 8'hFF);
          write_reg(CFG_TAB, 8'd79);
        end
        1: begin
          write_reg(CFG_ATTR, 8'h00);
          write_reg(CFG_TAB, 8'd1);
        end
        default: begin
          write_reg(CFG_ATTR, 8'($urandom_range(255)));
          write_reg(CFG_TAB, 8'($urandom_range(79, 1)));
        end
      endcase
      cfg_we <= 1'b0;
      idle_pct = (phase < 2) ? 7 : (phase < 4) ? 71 : 0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // now and then hold off until everything outstanding has come back
        if ($urandom_range(149) == 0) drain();
        sender_gap(idle_pct);
        issue(random_request(), 1'b0, '0);
      end
    end

    // wait out the last results and any scroll blanking behind them
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (COLUMNS_DEF + 20) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
hw/rtl/tcc_pkg.sv
hw/rtl/tcc_front.sv
hw/rtl/tcc_queue.sv
hw/rtl/tcc_back.sv
hw/rtl/text_console_cursor_scroll.sv
dv/tb_text_console_cursor_scroll.sv
